@@ rtl/c2s_pkg.sv @@
// Shared types, constants and the arctangent table for the
// cartesian_to_spherical block. No dependencies.
`default_nettype none

package c2s_pkg;

  localparam int COORD_WIDTH_DEF   = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int FIELD_W           = 16;
  localparam int ANGLE_W           = 8;
  localparam int RADIUS_W          = 16;
  localparam int ANG_FRAC          = 16;
  localparam int ANG_W             = 25;
  localparam int TABLE_LEN         = 24;
  localparam int DEG_LIMIT         = 90;
  // Side data in the CORDIC chain: two lanes of {zero_den, special angle}, then radius.
  localparam int CORDIC_SIDE_W     = 2 * (1 + ANGLE_W) + RADIUS_W;

  typedef struct packed {
    logic signed [FIELD_W-1:0] x_coord;
    logic signed [FIELD_W-1:0] y_coord;
    logic signed [FIELD_W-1:0] z_coord;
  } vec_req_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] yaw_deg;
    logic signed [ANGLE_W-1:0] pitch_deg;
    logic        [RADIUS_W-1:0] radius;
  } sph_res_t;

  // atan(2^-i) in degrees, 16 fraction bits, rounded to nearest
  function automatic logic signed [ANG_W-1:0] atan_entry(input int i);
    logic signed [ANG_W-1:0] v;
    case (i)
      0:  v = ANG_W'(2949120);
      1:  v = ANG_W'(1740967);
      2:  v = ANG_W'(919879);
      3:  v = ANG_W'(466945);
      4:  v = ANG_W'(234379);
      5:  v = ANG_W'(117304);
      6:  v = ANG_W'(58666);
      7:  v = ANG_W'(29335);
      8:  v = ANG_W'(14668);
      9:  v = ANG_W'(7334);
      10: v = ANG_W'(3667);
      11: v = ANG_W'(1833);
      12: v = ANG_W'(917);
      13: v = ANG_W'(458);
      14: v = ANG_W'(229);
      15: v = ANG_W'(115);
      16: v = ANG_W'(57);
      17: v = ANG_W'(29);
      18: v = ANG_W'(14);
      19: v = ANG_W'(7);
      20: v = ANG_W'(4);
      21: v = ANG_W'(2);
      22: v = ANG_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Round half away from zero to whole degrees, clamp to +/-90
  function automatic logic signed [ANGLE_W-1:0] ang_round(input logic signed [ANG_W-1:0] z);
    logic [ANG_W-1:0] mag;
    logic [ANG_W-1:0] sum;
    logic [ANG_W-ANG_FRAC-1:0] d;
    logic [ANGLE_W-1:0] dc;
    mag = z[ANG_W-1] ? ANG_W'(-z) : z;
    sum = mag + ANG_W'(1 << (ANG_FRAC - 1));
    d   = sum[ANG_W-1:ANG_FRAC];
    if (d > (ANG_W-ANG_FRAC)'(DEG_LIMIT)) begin
      dc = ANGLE_W'(DEG_LIMIT);
    end else begin
      dc = d[ANGLE_W-1:0];
    end
    return z[ANG_W-1] ? ANGLE_W'(-dc) : dc;
  endfunction

endpackage

`default_nettype wire

@@ rtl/c2s_sqrt_cell.sv @@
// One cell of the digit-by-digit square root chain: one root bit per cell,
// two radicands side by side plus pass-through side data. Uses c2s_pkg.
`default_nettype none

module c2s_sqrt_cell import c2s_pkg::*; #(
  parameter int W      = COORD_WIDTH_DEF,
  parameter int SIDE_W = 3 * COORD_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire logic                in_valid,
  input  wire logic [2*W+1:0]      in_rad [2],
  input  wire logic [W+1:0]        in_rem [2],
  input  wire logic [W:0]          in_root [2],
  input  wire logic [SIDE_W-1:0]   in_side,
  output logic                     out_valid,
  output logic [2*W+1:0]           out_rad [2],
  output logic [W+1:0]             out_rem [2],
  output logic [W:0]               out_root [2],
  output logic [SIDE_W-1:0]        out_side
);

  logic [2*W+1:0] rad_next  [2];
  logic [W+1:0]   rem_next  [2];
  logic [W:0]     root_next [2];
  logic [W+3:0]   t         [2];
  logic [W+3:0]   trial     [2];

  // Bring down two radicand bits, try subtracting 4q+1
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      t[l]        = {in_rem[l], in_rad[l][2*W+1:2*W]};
      trial[l]    = {1'b0, in_root[l], 2'b01};
      rad_next[l] = {in_rad[l][2*W-1:0], 2'b00};
      if (t[l] >= trial[l]) begin
        rem_next[l]  = (W+2)'(t[l] - trial[l]);
        root_next[l] = {in_root[l][W-1:0], 1'b1};
      end else begin
        rem_next[l]  = t[l][W+1:0];
        root_next[l] = {in_root[l][W-1:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rad  <= rad_next;
      out_rem  <= rem_next;
      out_root <= root_next;
      out_side <= in_side;
    end
  end

endmodule

`default_nettype wire

@@ rtl/c2s_cordic_cell.sv @@
// One vectoring CORDIC micro-rotation for the yaw and pitch lanes, with
// pass-through side data. Uses c2s_pkg for the arctangent table.
`default_nettype none

module c2s_cordic_cell import c2s_pkg::*; #(
  parameter int CW     = COORD_WIDTH_DEF + 19,
  parameter int IDX    = 0,
  parameter int SIDE_W = CORDIC_SIDE_W
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire logic                     in_valid,
  input  wire logic signed [CW-1:0]     in_x [2],
  input  wire logic signed [CW-1:0]     in_y [2],
  input  wire logic signed [ANG_W-1:0]  in_z [2],
  input  wire logic [SIDE_W-1:0]        in_side,
  output logic                          out_valid,
  output logic signed [CW-1:0]          out_x [2],
  output logic signed [CW-1:0]          out_y [2],
  output logic signed [ANG_W-1:0]       out_z [2],
  output logic [SIDE_W-1:0]             out_side
);

  localparam logic signed [ANG_W-1:0] STEP = atan_entry(IDX);

  logic signed [CW-1:0]    x_next [2];
  logic signed [CW-1:0]    y_next [2];
  logic signed [ANG_W-1:0] z_next [2];
  logic signed [CW-1:0]    xs     [2];
  logic signed [CW-1:0]    ys     [2];

  // Rotate toward the x axis; shifts floor
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      xs[l] = in_x[l] >>> IDX;
      ys[l] = in_y[l] >>> IDX;
      if (!in_y[l][CW-1]) begin
        x_next[l] = in_x[l] + ys[l];
        y_next[l] = in_y[l] - xs[l];
        z_next[l] = in_z[l] + STEP;
      end else begin
        x_next[l] = in_x[l] - ys[l];
        y_next[l] = in_y[l] + xs[l];
        z_next[l] = in_z[l] - STEP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x    <= x_next;
      out_y    <= y_next;
      out_z    <= z_next;
      out_side <= in_side;
    end
  end

endmodule

`default_nettype wire

@@ rtl/cartesian_to_spherical.sv @@
// Cartesian to spherical converter: top level. Depends on c2s_pkg,
// c2s_sqrt_cell and c2s_cordic_cell.
//
// Takes one request per cycle while the output is not stalled, and returns
// one result per request, in order. A request passes through the registers
// for input capture, squaring and summing, the square-root cell chain
// (COORD_WIDTH + 1 cells, one root bit per cell), the CORDIC cell chain (one
// micro-rotation per cell) and the output register. The
// whole pipeline holds while a finished result is stalled at the output.
// Yaw is the half-plane atan(y/x), pitch is atan(z/h) with h the truncated
// horizontal distance, both rounded to whole degrees in -90..90; a zero
// denominator gives +/-90 by the numerator's sign, 0/0 gives 0. Radius is
// rounded and saturates at 65535. Inputs use their low COORD_WIDTH bits.
`default_nettype none

module cartesian_to_spherical import c2s_pkg::*; #(
  parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     vec_valid,
  output logic          vec_stall,
  input  wire vec_req_t vec,
  output logic          sph_valid,
  input  wire logic     sph_stall,
  output sph_res_t      sph
);

  localparam int W      = COORD_WIDTH;
  localparam int QW     = W + 1;
  localparam int RW     = 2 * W + 2;
  localparam int CW     = W + 19;
  localparam int N      = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
  localparam int SIDE_S = 3 * W;

  logic adv;
  assign adv       = !(sph_valid && sph_stall);
  assign vec_stall = !adv;

  // Input field extraction
  logic signed [W-1:0] xin, yin, zin;
  generate
    if (W <= FIELD_W) begin : g_narrow
      assign xin = vec.x_coord[W-1:0];
      assign yin = vec.y_coord[W-1:0];
      assign zin = vec.z_coord[W-1:0];
    end else begin : g_wide
      assign xin = W'(vec.x_coord);
      assign yin = W'(vec.y_coord);
      assign zin = W'(vec.z_coord);
    end
  endgenerate

  // Stage 0: capture
  logic                v0;
  logic signed [W-1:0] x0, y0, z0;
  // Stage 1: squares
  logic                v1;
  logic signed [W-1:0] x1, y1, z1;
  logic [2*W-1:0]      sq_x, sq_y, sq_z;
  logic [W-1:0]        ax, ay, az;
  // Stage 2: sums
  logic                v2;
  logic signed [W-1:0] x2, y2, z2;
  logic [2*W:0]        hsq;
  logic [RW-1:0]       ssum;

  assign ax = x0[W-1] ? W'(-x0) : x0;
  assign ay = y0[W-1] ? W'(-y0) : y0;
  assign az = z0[W-1] ? W'(-z0) : z0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (adv) begin
      v0 <= vec_valid;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x0   <= xin;
      y0   <= yin;
      z0   <= zin;
      sq_x <= ax * ax;
      sq_y <= ay * ay;
      sq_z <= az * az;
      x1   <= x0;
      y1   <= y0;
      z1   <= z0;
      hsq  <= (2*W+1)'(sq_x) + (2*W+1)'(sq_y);
      ssum <= RW'(sq_x) + RW'(sq_y) + RW'(sq_z);
      x2   <= x1;
      y2   <= y1;
      z2   <= z1;
    end
  end

  // Square-root cell chain: lane 0 is x^2+y^2+z^2, lane 1 is x^2+y^2
  logic              sv    [QW+1];
  logic [RW-1:0]     srad  [QW+1][2];
  logic [W+1:0]      srem  [QW+1][2];
  logic [W:0]        sroot [QW+1][2];
  logic [SIDE_S-1:0] sside [QW+1];

  assign sv[0]       = v2;
  assign srad[0][0]  = ssum;
  assign srad[0][1]  = RW'(hsq);
  assign srem[0][0]  = '0;
  assign srem[0][1]  = '0;
  assign sroot[0][0] = '0;
  assign sroot[0][1] = '0;
  assign sside[0]    = {x2, y2, z2};

  generate
    for (genvar k = 0; k < QW; k++) begin : g_sqrt
      c2s_sqrt_cell #(.W(W), .SIDE_W(SIDE_S)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .en       (adv),
        .in_valid (sv[k]),
        .in_rad   (srad[k]),
        .in_rem   (srem[k]),
        .in_root  (sroot[k]),
        .in_side  (sside[k]),
        .out_valid(sv[k+1]),
        .out_rad  (srad[k+1]),
        .out_rem  (srem[k+1]),
        .out_root (sroot[k+1]),
        .out_side (sside[k+1])
      );
    end
  endgenerate

  // Root rounding and CORDIC setup
  logic signed [W-1:0]       xs, ys, zs;
  logic [W:0]                r_rnd;
  logic [W:0]                h_root;
  logic [RADIUS_W-1:0]       rad16;
  logic signed [CW-1:0]      yaw_num, yaw_den;
  logic signed [ANGLE_W-1:0] yaw_spec, pitch_spec;
  logic                      yaw_zero, pitch_zero;

  assign xs     = sside[QW][3*W-1:2*W];
  assign ys     = sside[QW][2*W-1:W];
  assign zs     = sside[QW][W-1:0];
  assign h_root = sroot[QW][1];
  assign r_rnd  = sroot[QW][0] + QW'(srem[QW][0] > (W+2)'(sroot[QW][0]));

  generate
    if (QW > RADIUS_W) begin : g_sat
      assign rad16 = (r_rnd > QW'({RADIUS_W{1'b1}})) ? {RADIUS_W{1'b1}}
                                                      : r_rnd[RADIUS_W-1:0];
    end else begin : g_nosat
      assign rad16 = RADIUS_W'(r_rnd);
    end
  endgenerate

  // Negative x: atan(y/x) taken as atan(-y/-x)
  assign yaw_num = xs[W-1] ? -CW'(ys) : CW'(ys);
  assign yaw_den = xs[W-1] ? -CW'(xs) : CW'(xs);

  assign yaw_zero   = (xs == '0);
  assign yaw_spec   = (ys == '0) ? '0 : (ys[W-1] ? -ANGLE_W'(DEG_LIMIT) : ANGLE_W'(DEG_LIMIT));
  assign pitch_zero = (h_root == '0);
  assign pitch_spec = (zs == '0) ? '0 : (zs[W-1] ? -ANGLE_W'(DEG_LIMIT) : ANGLE_W'(DEG_LIMIT));

  // CORDIC cell chain: lane 0 yaw, lane 1 pitch
  logic                     cv    [N+1];
  logic signed [CW-1:0]     cx    [N+1][2];
  logic signed [CW-1:0]     cy    [N+1][2];
  logic signed [ANG_W-1:0]  cz    [N+1][2];
  logic [CORDIC_SIDE_W-1:0] cside [N+1];

  assign cv[0]    = sv[QW];
  assign cx[0][0] = yaw_den <<< ANG_FRAC;
  assign cy[0][0] = yaw_num <<< ANG_FRAC;
  assign cx[0][1] = CW'(h_root) <<< ANG_FRAC;
  assign cy[0][1] = CW'(zs) <<< ANG_FRAC;
  assign cz[0][0] = '0;
  assign cz[0][1] = '0;
  assign cside[0] = {yaw_zero, yaw_spec, pitch_zero, pitch_spec, rad16};

  generate
    for (genvar k = 0; k < N; k++) begin : g_cordic
      c2s_cordic_cell #(.CW(CW), .IDX(k), .SIDE_W(CORDIC_SIDE_W)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .en       (adv),
        .in_valid (cv[k]),
        .in_x     (cx[k]),
        .in_y     (cy[k]),
        .in_z     (cz[k]),
        .in_side  (cside[k]),
        .out_valid(cv[k+1]),
        .out_x    (cx[k+1]),
        .out_y    (cy[k+1]),
        .out_z    (cz[k+1]),
        .out_side (cside[k+1])
      );
    end
  endgenerate

  // Final rounding, special cases, output register
  logic                      fy_zero, fp_zero;
  logic signed [ANGLE_W-1:0] fy_spec, fp_spec;
  logic [RADIUS_W-1:0]       f_rad;
  sph_res_t                  res_next;

  assign {fy_zero, fy_spec, fp_zero, fp_spec, f_rad} = cside[N];

  always_comb begin
    res_next.yaw_deg   = fy_zero ? fy_spec : ang_round(cz[N][0]);
    res_next.pitch_deg = fp_zero ? fp_spec : ang_round(cz[N][1]);
    res_next.radius    = f_rad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sph_valid <= 1'b0;
    end else if (adv) begin
      sph_valid <= cv[N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sph <= res_next;
    end
  end

`ifndef SYNTHESIS
  a_yaw_range: assert property (@(posedge clk) disable iff (rst)
    sph_valid |-> (sph.yaw_deg <= 8'sd90 && sph.yaw_deg >= -8'sd90))
    else $error("yaw out of range");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    sph_valid |-> (sph.pitch_deg <= 8'sd90 && sph.pitch_deg >= -8'sd90))
    else $error("pitch out of range");

  a_zero_vector: assert property (@(posedge clk) disable iff (rst)
    (sph_valid && sph.radius == '0) |-> (sph.yaw_deg == '0 && sph.pitch_deg == '0))
    else $error("zero vector gave nonzero angle");
`endif

endmodule

`default_nettype wire

@@ test/tb_cartesian_to_spherical.sv @@
// Testbench for cartesian_to_spherical: drives vector requests, predicts yaw,
// pitch and radius with a bit-exact CORDIC model and checks every result.
// Depends on c2s_pkg and the cartesian_to_spherical RTL.
`default_nettype none

module tb_cartesian_to_spherical;
  import c2s_pkg::*;

  // Bit-exact model of the conversion and a queue of pending results
  class sph_scoreboard;
    sph_res_t pending_q[$];
    int errors = 0;

    function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // Vectoring CORDIC arctangent in rounded degrees, den >= 0
    function automatic logic signed [ANGLE_W-1:0] atan_deg(input longint num,
                                                          input longint den);
      longint cx, cy, ang, xs, ys, mag, d;
      if (den == 0) begin
        if (num > 0) return ANGLE_W'(DEG_LIMIT);
        if (num < 0) return ANGLE_W'(-DEG_LIMIT);
        return '0;
      end
      cx = den * 65536;
      cy = num * 65536;
      ang = 0;
      for (int i = 0; i < CORDIC_STAGES_DEF && i < TABLE_LEN; i++) begin
        xs = cx >>> i;
        ys = cy >>> i;
        if (cy >= 0) begin
          cx = cx + ys; cy = cy - xs; ang = ang + longint'(atan_entry(i));
        end else begin
          cx = cx - ys; cy = cy + xs; ang = ang - longint'(atan_entry(i));
        end
      end
      mag = (ang < 0) ? -ang : ang;
      d = (mag + (64'd1 << (ANG_FRAC - 1))) >>> ANG_FRAC;
      if (d > DEG_LIMIT) d = DEG_LIMIT;
      return (ang < 0) ? ANGLE_W'(-d) : ANGLE_W'(d);
    endfunction

    function void note_request(input vec_req_t v);
      longint x, y, z;
      longint unsigned hsq, s, h, r;
      sph_res_t e;
      x = v.x_coord; y = v.y_coord; z = v.z_coord;
      hsq = x * x + y * y;
      s = hsq + z * z;
      h = int_sqrt(hsq);
      r = int_sqrt(s);
      if (s > r * r + r) r = r + 1;
      if (r > 65535) r = 65535;
      e.yaw_deg = (x < 0) ? atan_deg(-y, -x) : atan_deg(y, x);
      e.pitch_deg = atan_deg(z, longint'(h));
      e.radius = r[RADIUS_W-1:0];
      pending_q.push_back(e);
    endfunction

    function void check_result(input sph_res_t got);
      sph_res_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (got.yaw_deg !== e.yaw_deg) begin
        $display("%0t: yaw exp %0d got %0d", $time, e.yaw_deg, got.yaw_deg);
        errors++;
      end
      if (got.pitch_deg !== e.pitch_deg) begin
        $display("%0t: pitch exp %0d got %0d", $time, e.pitch_deg, got.pitch_deg);
        errors++;
      end
      if (got.radius !== e.radius) begin
        $display("%0t: radius exp %0d got %0d", $time, e.radius, got.radius);
        errors++;
      end
    endfunction
  endclass

  localparam int LATENCY = COORD_WIDTH_DEF + CORDIC_STAGES_DEF + 5;
  localparam int WATCHDOG = 2000;

  logic clk = 0;
  logic rst = 1;
  logic vec_valid = 0;
  logic vec_stall;
  vec_req_t vec = '0;
  logic sph_valid;
  logic sph_stall = 0;
  sph_res_t sph;

  sph_scoreboard sb = new();
  bit quiet = 0;        // no idling in the last part
  bit hold_off = 0;     // long receiver hold-off request
  int idle_cycles = 0;

  cartesian_to_spherical dut (
    .clk(clk), .rst(rst), .vec_valid(vec_valid), .vec_stall(vec_stall),
    .vec(vec), .sph_valid(sph_valid), .sph_stall(sph_stall), .sph(sph)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Check results and run the watchdog at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (sph_valid && !sph_stall) sb.check_result(sph);
      if ((vec_valid && !vec_stall) || (sph_valid && !sph_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Receiver stall: random bursts, or a long hold-off when asked
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (hold_off) begin
        sph_stall <= 1;
        repeat (200) @(negedge clk);
        sph_stall <= 0;
        hold_off = 0;
        @(negedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 15);
        sph_stall <= 1;
        repeat (n) @(negedge clk);
        sph_stall <= 0;
        @(negedge clk);
      end else begin
        sph_stall <= 0;
        @(negedge clk);
      end
    end
  end

  // Offer one request and hold it until accepted
  task automatic send_request(input vec_req_t v, input bit allow_gap);
    int n;
    if (allow_gap && !quiet && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 15);
      vec_valid <= 0;
      repeat (n) @(negedge clk);
    end
    vec <= v;
    vec_valid <= 1;
    @(posedge clk);
    while (vec_stall) @(posedge clk);
    sb.note_request(v);
    @(negedge clk);
  endtask

  task automatic send_xyz(input int x, input int y, input int z);
    vec_req_t v;
    v.x_coord = FIELD_W'(x);
    v.y_coord = FIELD_W'(y);
    v.z_coord = FIELD_W'(z);
    send_request(v, 1);
  endtask

  function automatic int rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 6) - 3;
      1: return $urandom_range(0, 200) - 100;
      2: return $urandom_range(0, 1) ? 32767 - $urandom_range(0, 3)
                                      : -32768 + $urandom_range(0, 3);
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  task automatic drain();
    vec_valid <= 0;
    while (sb.pending_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    int t;
    repeat (11) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed: extremes, zero denominators, zero over zero, negative x
    send_xyz(0, 0, 0);
    send_xyz(0, 5, 0);
    send_xyz(0, -5, 0);
    send_xyz(0, 0, 7);
    send_xyz(0, 0, -7);
    send_xyz(32767, 32767, 32767);
    send_xyz(-32768, -32768, -32768);
    send_xyz(-32768, 32767, -32768);
    send_xyz(32767, -32768, 32767);
    send_xyz(-1, 1, 0);
    send_xyz(-5, -5, 3);
    send_xyz(1, 0, 0);
    send_xyz(-1, 0, 0);
    send_xyz(1, 1, 1);
    send_xyz(100, 100, -1);
    send_xyz(-32768, 0, 0);
    send_xyz(0, -32768, 32767);
    send_xyz(3, 4, 12);
    send_xyz(-3, 4, -12);
    send_xyz(1, 32767, 1);
    send_xyz(32767, 1, -32768);

    // Sender pauses until every result is back
    drain();

    // Random traffic with a long receiver hold-off early on
    for (int i = 0; i < 650; i++) begin
      if (i == 50) hold_off = 1;
      if (i == 560) quiet = 1;
      send_xyz(rand_coord(), rand_coord(), rand_coord());
    end
    vec_valid <= 0;

    t = 0;
    while (sb.pending_q.size() != 0 && t < 100000) begin
      @(negedge clk);
      t++;
    end
    repeat (LATENCY + 5) @(negedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

`default_nettype wire
